>>> design/crs_pkg.sv
// Shared types and constants for the coalescing range set.
package crs_pkg;

   localparam int MaxRangesDefault = 32;
   localparam int PointW           = 32;
   localparam int EntryW           = 2 * PointW;
   localparam int CountOutW        = 6;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_INVERT = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [PointW:0] MaxNarrow = 33'h0_0000_FFFF;
   localparam logic [PointW:0] MaxWide   = 33'h0_FFFF_FFFF;

   typedef struct packed {
      logic              below;
      logic              above;
      logic [PointW-1:0] merged_low;
      logic [PointW-1:0] merged_high;
      logic              inv_stop;
      logic              inv_gap;
      logic [PointW-1:0] gap_end;
      logic [PointW:0]   new_cursor;
      logic              tail;
   } alu_out_type;

endpackage

>>> design/crs_ram.sv
// Generic single write port RAM with registered read.
module crs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/crs_alu.sv
// Shared compare unit for merging and inverting one stored range.
module crs_alu (
   input  logic [crs_pkg::PointW-1:0] entry_start,
   input  logic [crs_pkg::PointW-1:0] entry_end,
   input  logic [crs_pkg::PointW-1:0] ins_low,
   input  logic [crs_pkg::PointW-1:0] ins_high,
   input  logic [crs_pkg::PointW:0]   cursor,
   input  logic [crs_pkg::PointW:0]   max_value,
   output crs_pkg::alu_out_type       result
);
   import crs_pkg::*;

   logic [PointW:0] s_ext, e_ext, e_clip, e_next;

   always_comb begin
      s_ext  = {1'b0, entry_start};
      e_ext  = {1'b0, entry_end};
      e_clip = (e_ext > max_value) ? max_value : e_ext;
      e_next = e_clip + 33'd1;
      result.below       = (e_ext + 33'd1) < {1'b0, ins_low};
      result.above       = s_ext > ({1'b0, ins_high} + 33'd1);
      result.merged_low  = (entry_start < ins_low) ? entry_start : ins_low;
      result.merged_high = (entry_end > ins_high) ? entry_end : ins_high;
      result.inv_stop    = (s_ext > max_value) || (cursor > max_value);
      result.inv_gap     = s_ext > cursor;
      result.gap_end     = entry_start - 32'd1;
      result.new_cursor  = (e_next > cursor) ? e_next : cursor;
      result.tail        = cursor <= max_value;
   end

endmodule

>>> design/coalescing_range_set.sv
// Top level of the coalescing range set: sequencer, table banks and result register.
// Clear and empty inserts answer straight from idle; insert and invert read each of the
// N stored ranges from the RAM in turn, with one compare step per range.
// Read-out gives one beat per range and waits for rsp_ready before the next one.
// Throughput: one item at a time; req_ready is high only while the sequencer is idle.
// Reset: synchronous, active high; clears the range count, sequencer and result valid.
module coalescing_range_set #(
   parameter int MAX_RANGES = crs_pkg::MaxRangesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [crs_pkg::PointW-1:0]    req_range_low,
   input  logic [crs_pkg::PointW-1:0]    req_range_high,
   input  logic                          req_wide_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [crs_pkg::PointW-1:0]    rsp_out_low,
   output logic [crs_pkg::PointW-1:0]    rsp_out_high,
   output logic                          rsp_out_valid,
   output logic                          rsp_last,
   output logic [1:0]                    rsp_status,
   output logic [crs_pkg::CountOutW-1:0] rsp_range_count
);
   import crs_pkg::*;

   // Address width covers the table; counters can also hold MAX_RANGES + 1,
   // which is how many entries an invert may produce before it is rejected.
   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 2);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_RANGES);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ISSUE  = 4'd1;
   localparam logic [3:0] S_INS    = 4'd2;
   localparam logic [3:0] S_FINAL  = 4'd3;
   localparam logic [3:0] S_INV    = 4'd4;
   localparam logic [3:0] S_TAIL   = 4'd5;
   localparam logic [3:0] S_COMMIT = 4'd6;
   localparam logic [3:0] S_RD     = 4'd7;
   localparam logic [3:0] S_WAIT   = 4'd8;

   logic [3:0]        state_ff, state_in, after_ff, after_in;
   logic [1:0]        op_ff, op_in;
   logic [CW-1:0]     i_ff, i_in, n_ff, n_in, count_ff, count_in;
   logic              placed_ff, placed_in, sel_ff, sel_in, wide_ff, wide_in;
   logic [PointW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [PointW:0]   cur_ff, cur_in, max_value;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PointW-1:0]    out_low_ff, out_low_in, out_high_ff, out_high_in;
   logic                 out_valid_ff, out_valid_in, last_ff, last_in;
   logic [1:0]           status_ff, status_in;
   logic [CountOutW-1:0] rcount_ff, rcount_in;

   logic              we, re;
   logic [EntryW-1:0] wdata, rdata0, rdata1, rdata;
   logic [PointW-1:0] s_val, e_val;
   alu_out_type       alu;

   // Two banks: the table in use is read from bank sel_ff while the rebuilt
   // table is written into the other one. A successful update just flips sel_ff.
   crs_ram #(.WIDTH(EntryW), .DEPTH(MAX_RANGES)) u_bank0 (
      .clock(clock), .we(we & sel_ff), .waddr(n_ff[IW-1:0]), .wdata(wdata),
      .re(re & ~sel_ff), .raddr(i_ff[IW-1:0]), .rdata(rdata0)
   );

   crs_ram #(.WIDTH(EntryW), .DEPTH(MAX_RANGES)) u_bank1 (
      .clock(clock), .we(we & ~sel_ff), .waddr(n_ff[IW-1:0]), .wdata(wdata),
      .re(re & sel_ff), .raddr(i_ff[IW-1:0]), .rdata(rdata1)
   );

   assign rdata     = sel_ff ? rdata1 : rdata0;
   assign s_val     = rdata[EntryW-1:PointW];
   assign e_val     = rdata[PointW-1:0];
   assign max_value = wide_ff ? MaxWide : MaxNarrow;

   crs_alu u_alu (
      .entry_start(s_val), .entry_end(e_val), .ins_low(lo_ff), .ins_high(hi_ff),
      .cursor(cur_ff), .max_value(max_value), .result(alu)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      op_in        = op_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      placed_in    = placed_ff;
      sel_in       = sel_ff;
      wide_in      = wide_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      out_low_in   = out_low_ff;
      out_high_in  = out_high_ff;
      out_valid_in = out_valid_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      rcount_in    = rcount_ff;
      we           = 1'b0;
      re           = 1'b0;
      wdata        = {s_val, e_val};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_action;
               lo_in        = req_range_low;
               hi_in        = req_range_high;
               wide_in      = req_wide_mode;
               i_in         = '0;
               n_in         = '0;
               placed_in    = 1'b0;
               cur_in       = '0;
               // A beat that carries no stored range by default.
               out_low_in   = '0;
               out_high_in  = '0;
               out_valid_in = 1'b0;
               last_in      = 1'b1;
               status_in    = ST_OK;
               rcount_in    = CountOutW'(count_ff);
               after_in     = S_IDLE;
               unique case (req_action)
                  ACT_CLEAR: begin
                     count_in     = '0;
                     rcount_in    = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = S_WAIT;
                  end
                  ACT_INSERT: begin
                     if (req_range_low > req_range_high) begin
                        status_in    = ST_EMPTY;
                        rsp_valid_in = 1'b1;
                        state_in     = S_WAIT;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
                  ACT_INVERT: begin
                     state_in = S_ISSUE;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_WAIT;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
               endcase
            end
         end
         S_ISSUE: begin
            if (i_ff == count_ff) begin
               state_in = (op_ff == ACT_INSERT) ? S_FINAL : S_TAIL;
            end else begin
               re = 1'b1;
               unique case (op_ff)
                  ACT_INSERT: state_in = S_INS;
                  ACT_INVERT: state_in = S_INV;
                  default:    state_in = S_RD;
               endcase
            end
         end
         S_INS: begin
            if (alu.below) begin
               we       = (n_ff < MaxCount);
               n_in     = n_ff + 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = S_ISSUE;
            end else if (alu.above) begin
               if (!placed_ff) begin
                  // Place the new range first; the read data holds for the next cycle.
                  we        = (n_ff < MaxCount);
                  wdata     = {lo_ff, hi_ff};
                  n_in      = n_ff + 1'b1;
                  placed_in = 1'b1;
               end else begin
                  we       = (n_ff < MaxCount);
                  n_in     = n_ff + 1'b1;
                  i_in     = i_ff + 1'b1;
                  state_in = S_ISSUE;
               end
            end else begin
               lo_in    = alu.merged_low;
               hi_in    = alu.merged_high;
               i_in     = i_ff + 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_FINAL: begin
            if (!placed_ff) begin
               we    = (n_ff < MaxCount);
               wdata = {lo_ff, hi_ff};
               n_in  = n_ff + 1'b1;
            end
            state_in = S_COMMIT;
         end
         S_INV: begin
            if (alu.inv_stop) begin
               state_in = S_TAIL;
            end else begin
               if (alu.inv_gap) begin
                  we    = (n_ff < MaxCount);
                  wdata = {cur_ff[PointW-1:0], alu.gap_end};
                  n_in  = n_ff + 1'b1;
               end
               cur_in   = alu.new_cursor;
               i_in     = i_ff + 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_TAIL: begin
            if (alu.tail) begin
               we    = (n_ff < MaxCount);
               wdata = {cur_ff[PointW-1:0], max_value[PointW-1:0]};
               n_in  = n_ff + 1'b1;
            end
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (n_ff > MaxCount) begin
               status_in = ST_FULL;
            end else begin
               count_in  = n_ff;
               rcount_in = CountOutW'(n_ff);
               sel_in    = ~sel_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_WAIT;
         end
         S_RD: begin
            out_low_in   = s_val;
            out_high_in  = e_val;
            out_valid_in = 1'b1;
            last_in      = (i_ff + 1'b1 == count_ff);
            rsp_valid_in = 1'b1;
            after_in     = (i_ff + 1'b1 == count_ff) ? S_IDLE : S_ISSUE;
            i_in         = i_ff + 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = after_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= S_IDLE;
         count_ff     <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         count_ff     <= count_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      i_ff         <= i_in;
      n_ff         <= n_in;
      placed_ff    <= placed_in;
      wide_ff      <= wide_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      cur_ff       <= cur_in;
      out_low_ff   <= out_low_in;
      out_high_ff  <= out_high_in;
      out_valid_ff <= out_valid_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
      rcount_ff    <= rcount_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_low     = out_low_ff;
   assign rsp_out_high    = out_high_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;
   assign rsp_range_count = rcount_ff;

endmodule
